FILE: rtl/udv_pkg.sv
// Shared types, byte classes, error codes and range limits of the UTF-8 decoder.
package udv_pkg;

	// one input item: a raw byte and the last-byte flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} byte_item_t;

	// one result item
	typedef struct packed {
		logic        char_valid;
		logic [20:0] code_point;
		logic [2:0]  char_width;
		logic [3:0]  error_code;
		logic        buffer_end;
		logic        buffer_valid;
	} result_t;

	// byte classes found by the front end
	localparam logic [2:0] CLS_ASCII = 3'd0;
	localparam logic [2:0] CLS_CONT  = 3'd1;
	localparam logic [2:0] CLS_C0C1  = 3'd2;
	localparam logic [2:0] CLS_LEAD2 = 3'd3;
	localparam logic [2:0] CLS_LEAD3 = 3'd4;
	localparam logic [2:0] CLS_LEAD4 = 3'd5;
	localparam logic [2:0] CLS_HIGH  = 3'd6;

	// classified item between front and back
	typedef struct packed {
		logic [2:0] cls;
		logic [6:0] bits;   // payload bits of the byte, already masked
		logic       last;
	} cls_item_t;

	// error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_STRAY     = 4'd1;
	localparam logic [3:0] ERR_C0C1      = 4'd2;
	localparam logic [3:0] ERR_HIGH_LEAD = 4'd3;
	localparam logic [3:0] ERR_MISSING   = 4'd4;
	localparam logic [3:0] ERR_OVERLONG  = 4'd5;
	localparam logic [3:0] ERR_SURROGATE = 4'd6;
	localparam logic [3:0] ERR_ABOVE_MAX = 4'd7;
	localparam logic [3:0] ERR_TRUNC     = 4'd8;

	// range limits
	localparam logic [20:0] MIN_LEN2  = 21'h00080;
	localparam logic [20:0] MIN_LEN3  = 21'h00800;
	localparam logic [20:0] MIN_LEN4  = 21'h10000;
	localparam logic [20:0] SURR_LO   = 21'h0D800;
	localparam logic [20:0] SURR_HI   = 21'h0DFFF;
	localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;

	// 2-entry queues
	localparam int unsigned QUEUE_DEPTH = 2;

endpackage

FILE: rtl/udv_classify.sv
// Front end: sorts each incoming byte into its UTF-8 class and masks its payload bits.
module udv_classify (
	input  udv_pkg::byte_item_t byte_item,
	output udv_pkg::cls_item_t  cls_item
);

	logic [7:0] b;

	assign b = byte_item.data_byte;

	always_comb begin
		cls_item.last = byte_item.end_of_buffer;
		cls_item.bits = b[6:0];
		if (b inside {[8'h00:8'h7F]}) begin
			cls_item.cls  = udv_pkg::CLS_ASCII;
		end else if (b inside {[8'h80:8'hBF]}) begin
			cls_item.cls  = udv_pkg::CLS_CONT;
			cls_item.bits = {1'b0, b[5:0]};
		end else if (b inside {[8'hC0:8'hC1]}) begin
			cls_item.cls  = udv_pkg::CLS_C0C1;
		end else if (b inside {[8'hC2:8'hDF]}) begin
			cls_item.cls  = udv_pkg::CLS_LEAD2;
			cls_item.bits = {2'b00, b[4:0]};
		end else if (b inside {[8'hE0:8'hEF]}) begin
			cls_item.cls  = udv_pkg::CLS_LEAD3;
			cls_item.bits = {3'b000, b[3:0]};
		end else if (b inside {[8'hF0:8'hF4]}) begin
			cls_item.cls  = udv_pkg::CLS_LEAD4;
			cls_item.bits = {4'b0000, b[2:0]};
		end else begin
			cls_item.cls  = udv_pkg::CLS_HIGH;
		end
	end

endmodule

FILE: rtl/udv_queue.sv
// Two-entry queue of classified items between the front end and the decoder.
module udv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  udv_pkg::cls_item_t wr_item,
	output logic               full,
	input  logic               rd_en,
	output logic               rd_valid,
	output udv_pkg::cls_item_t rd_item
);

	udv_pkg::cls_item_t slot_q [udv_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd)      count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_item;
	end

endmodule

FILE: rtl/udv_back.sv
// Back end: sequence state, range checks and the two-entry result queue.
module udv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  udv_pkg::cls_item_t in_item,
	output logic               in_take,
	output logic               empty,
	input  logic               pop,
	output udv_pkg::result_t   result
);

	// decoder state
	logic [1:0]  pend_q;
	logic [2:0]  len_q;
	logic [20:0] acc_q;
	logic        err_seen_q;

	logic [1:0]  pend_n;
	logic [2:0]  len_n;
	logic [20:0] acc_n;
	logic        err_seen_n;
	logic        emit;
	udv_pkg::result_t res;

	// result queue
	udv_pkg::result_t rslot_q [udv_pkg::QUEUE_DEPTH];
	logic       rwr_ptr_q;
	logic       rrd_ptr_q;
	logic [1:0] rcount_q;
	logic       rfull;
	logic       do_push;
	logic       do_pop;

	logic [20:0] acc_sh;
	logic [3:0]  err;

	assign rfull   = (rcount_q == 2'd2);
	assign in_take = in_valid && !rfull;
	assign acc_sh  = {acc_q[14:0], in_item.bits[5:0]};

	always_comb begin
		pend_n     = pend_q;
		len_n      = len_q;
		acc_n      = acc_q;
		err_seen_n = err_seen_q;
		err        = udv_pkg::ERR_NONE;
		emit       = 1'b0;
		res        = '0;

		if (!err_seen_q) begin
			if (pend_q != 2'd0) begin
				if (in_item.cls == udv_pkg::CLS_CONT) begin
					acc_n  = acc_sh;
					pend_n = pend_q - 2'd1;
					if (pend_q == 2'd1) begin
						// final byte: range checks on the assembled value
						case (len_q)
							3'd2: begin
								if (acc_sh < udv_pkg::MIN_LEN2) err = udv_pkg::ERR_OVERLONG;
							end
							3'd3: begin
								if (acc_sh < udv_pkg::MIN_LEN3) err = udv_pkg::ERR_OVERLONG;
								else if (acc_sh >= udv_pkg::SURR_LO &&
									acc_sh <= udv_pkg::SURR_HI)
									err = udv_pkg::ERR_SURROGATE;
							end
							3'd4: begin
								if (acc_sh < udv_pkg::MIN_LEN4) err = udv_pkg::ERR_OVERLONG;
								else if (acc_sh > udv_pkg::MAX_SCALAR)
									err = udv_pkg::ERR_ABOVE_MAX;
							end
							default: begin
								err = udv_pkg::ERR_NONE;
							end
						endcase
						if (err == udv_pkg::ERR_NONE) begin
							res.char_valid = 1'b1;
							res.code_point = acc_sh;
							res.char_width = len_q;
						end
						emit   = 1'b1;
						pend_n = 2'd0;
						len_n  = 3'd0;
						acc_n  = '0;
					end
				end else begin
					err  = udv_pkg::ERR_MISSING;
					emit = 1'b1;
				end
			end else begin
				case (in_item.cls)
					udv_pkg::CLS_ASCII: begin
						res.char_valid = 1'b1;
						res.code_point = {14'd0, in_item.bits};
						res.char_width = 3'd1;
						emit = 1'b1;
					end
					udv_pkg::CLS_CONT: begin
						err  = udv_pkg::ERR_STRAY;
						emit = 1'b1;
					end
					udv_pkg::CLS_C0C1: begin
						err  = udv_pkg::ERR_C0C1;
						emit = 1'b1;
					end
					udv_pkg::CLS_LEAD2: begin
						pend_n = 2'd1;
						len_n  = 3'd2;
						acc_n  = {14'd0, in_item.bits};
					end
					udv_pkg::CLS_LEAD3: begin
						pend_n = 2'd2;
						len_n  = 3'd3;
						acc_n  = {14'd0, in_item.bits};
					end
					udv_pkg::CLS_LEAD4: begin
						pend_n = 2'd3;
						len_n  = 3'd4;
						acc_n  = {14'd0, in_item.bits};
					end
					default: begin
						err  = udv_pkg::ERR_HIGH_LEAD;
						emit = 1'b1;
					end
				endcase
			end

			if (err != udv_pkg::ERR_NONE) begin
				err_seen_n = 1'b1;
				pend_n     = 2'd0;
				len_n      = 3'd0;
				acc_n      = '0;
			end else if (in_item.last && pend_n != 2'd0) begin
				// sequence still open at the end byte
				err        = udv_pkg::ERR_TRUNC;
				err_seen_n = 1'b1;
				emit       = 1'b1;
			end
		end

		res.error_code   = err;
		res.buffer_end   = in_item.last;
		res.buffer_valid = in_item.last && !err_seen_n;

		if (in_item.last) begin
			emit       = 1'b1;
			pend_n     = 2'd0;
			len_n      = 3'd0;
			acc_n      = '0;
			err_seen_n = 1'b0;
		end
	end

	assign do_push = in_take && emit;
	assign do_pop  = pop && !empty;
	assign empty   = (rcount_q == 2'd0);
	assign result  = rslot_q[rrd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 2'd0;
			len_q      <= 3'd0;
			acc_q      <= '0;
			err_seen_q <= 1'b0;
			rwr_ptr_q  <= 1'b0;
			rrd_ptr_q  <= 1'b0;
			rcount_q   <= 2'd0;
		end else begin
			if (in_take) begin
				pend_q     <= pend_n;
				len_q      <= len_n;
				acc_q      <= acc_n;
				err_seen_q <= err_seen_n;
			end
			if (do_push) rwr_ptr_q <= ~rwr_ptr_q;
			if (do_pop)  rrd_ptr_q <= ~rrd_ptr_q;
			if (do_push && !do_pop)      rcount_q <= rcount_q + 2'd1;
			else if (do_pop && !do_push) rcount_q <= rcount_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) rslot_q[rwr_ptr_q] <= res;
	end

endmodule

FILE: rtl/utf8_stream_decoder_validator.sv
// Top level of the UTF-8 stream decoder and validator.
// Path: an accepted byte goes into the middle queue; the back end decodes it at the
//   queue head and writes its result into the result queue, after which empty falls.
// Throughput: one byte per cycle unless results back up; decode is combinational.
// Reset: arst_n clears both queues and the sequence state at once; no clearing pass.
module utf8_stream_decoder_validator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  udv_pkg::byte_item_t byte_item,
	output logic                empty,
	input  logic                pop,
	output udv_pkg::result_t    result
);

	// front end: classification happens on the way into the middle queue,
	// so the queue holds class codes and masked payload bits, not raw bytes
	udv_pkg::cls_item_t cls_in;
	udv_pkg::cls_item_t cls_head;
	logic               head_valid;
	logic               head_take;

	udv_classify u_classify (
		.byte_item (byte_item),
		.cls_item  (cls_in)
	);

	// middle queue: lets the byte source and the decoder stall on their own;
	// full is a registered count, so push never waits on pop combinationally
	udv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_item  (cls_in),
		.full     (full),
		.rd_en    (head_take),
		.rd_valid (head_valid),
		.rd_item  (cls_head)
	);

	// back end: takes one classified item a cycle while its result queue has
	// room; an item that causes no result still moves the state on
	udv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (head_valid),
		.in_item  (cls_head),
		.in_take  (head_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

FILE: tb/utf8_decode_checker.sv
// Checker for the UTF-8 decoder: predicts each result from accepted bytes and compares.
module utf8_decode_checker
	import udv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  byte_item_t  byte_item,
	input  logic        empty,
	input  logic        pop,
	input  result_t     result,
	output int unsigned fail_count,
	output int unsigned results_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] ASCII_HI = 8'h7F;
	localparam logic [7:0] CONT_LO  = 8'h80;
	localparam logic [7:0] CONT_HI  = 8'hBF;
	localparam logic [7:0] C0C1_HI  = 8'hC1;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	// predicted decoder state
	logic [1:0]  cont_left;
	logic [2:0]  seq_len;
	logic [20:0] partial_cp;
	logic        err_flag;

	result_t expected_results[$];
	result_t oldest;
	result_t predicted;

	function automatic void clear_seq();
		cont_left  = '0;
		seq_len    = '0;
		partial_cp = '0;
	endfunction

	function automatic logic [3:0] range_error(logic [2:0] len, logic [20:0] cp);
		logic [3:0] code;
		code = ERR_NONE;
		case (len)
			3'd2: begin
				if (cp < MIN_LEN2) code = ERR_OVERLONG;
			end
			3'd3: begin
				if (cp < MIN_LEN3) code = ERR_OVERLONG;
				else if (cp >= SURR_LO && cp <= SURR_HI) code = ERR_SURROGATE;
			end
			3'd4: begin
				if (cp < MIN_LEN4) code = ERR_OVERLONG;
				else if (cp > MAX_SCALAR) code = ERR_ABOVE_MAX;
			end
			default: code = ERR_NONE;
		endcase
		return code;
	endfunction

	// advance the predicted state by one byte; returns 1 when a result is due
	function automatic bit decode_byte(input byte_item_t item, output result_t res);
		logic [7:0] b;
		logic [3:0] code;
		bit         emit;
		b    = item.data_byte;
		code = ERR_NONE;
		emit = 1'b0;
		res  = '0;
		if (!err_flag) begin
			if (cont_left != 2'd0) begin
				if (b >= CONT_LO && b <= CONT_HI) begin
					partial_cp = {partial_cp[14:0], b[5:0]};
					cont_left  = cont_left - 2'd1;
					if (cont_left == 2'd0) begin
						code = range_error(seq_len, partial_cp);
						if (code == ERR_NONE) begin
							res.char_valid = 1'b1;
							res.code_point = partial_cp;
							res.char_width = seq_len;
						end
						emit = 1'b1;
						clear_seq();
					end
				end else begin
					// not reread as a lead
					code = ERR_MISSING;
					emit = 1'b1;
				end
			end else if (b <= ASCII_HI) begin
				res.char_valid = 1'b1;
				res.code_point = {13'd0, b};
				res.char_width = 3'd1;
				emit = 1'b1;
			end else if (b <= CONT_HI) begin
				code = ERR_STRAY;
				emit = 1'b1;
			end else if (b <= C0C1_HI) begin
				code = ERR_C0C1;
				emit = 1'b1;
			end else if (b <= LEAD2_HI) begin
				cont_left  = 2'd1;
				seq_len    = 3'd2;
				partial_cp = {16'd0, b[4:0]};
			end else if (b <= LEAD3_HI) begin
				cont_left  = 2'd2;
				seq_len    = 3'd3;
				partial_cp = {17'd0, b[3:0]};
			end else if (b <= LEAD4_HI) begin
				cont_left  = 2'd3;
				seq_len    = 3'd4;
				partial_cp = {18'd0, b[2:0]};
			end else begin
				code = ERR_HIGH_LEAD;
				emit = 1'b1;
			end
			if (code != ERR_NONE) begin
				err_flag = 1'b1;
				clear_seq();
			end else if (item.end_of_buffer && cont_left != 2'd0) begin
				code     = ERR_TRUNC;
				err_flag = 1'b1;
				emit     = 1'b1;
			end
		end
		if (item.end_of_buffer) emit = 1'b1;
		res.error_code   = code;
		res.buffer_end   = item.end_of_buffer;
		res.buffer_valid = item.end_of_buffer && !err_flag;
		if (item.end_of_buffer) begin
			clear_seq();
			err_flag = 1'b0;
		end
		return emit;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_seq();
			err_flag = 1'b0;
			expected_results.delete();
			fail_count = 0;
			results_outstanding <= 0;
		end else begin
			// results first: none can stem from a byte taken at this same edge
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result item with nothing expected: 0x%0h", result);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("char_valid", oldest.char_valid, result.char_valid);
					check_field("code_point", oldest.code_point, result.code_point);
					check_field("char_width", oldest.char_width, result.char_width);
					check_field("error_code", oldest.error_code, result.error_code);
					check_field("buffer_end", oldest.buffer_end, result.buffer_end);
					check_field("buffer_valid", oldest.buffer_valid, result.buffer_valid);
				end
			end
			if (push && !full) begin
				if (decode_byte(byte_item, predicted)) expected_results.push_back(predicted);
			end
			results_outstanding <= expected_results.size();
		end
	end

endmodule

FILE: tb/utf8_stream_decoder_validator_tb.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus, result draining, verdict.
module utf8_stream_decoder_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import udv_pkg::*;

	localparam int unsigned HALF_PERIOD  = 6;
	localparam int unsigned RESET_CYCLES = 10;
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned MAX_IDLE     = 17;
	// receiver stops taking results for this long once, so both queues fill
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned HOLD_AFTER   = 150;
	// spare cycles after the drain catch any stray results
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 400_000;

	// ways of spoiling a buffer in the random part
	typedef enum logic [2:0] {
		DEFECT_NOISE,
		DEFECT_STRAY,
		DEFECT_BAD_LEAD,
		DEFECT_MISSING,
		DEFECT_OVERLONG,
		DEFECT_SURROGATE,
		DEFECT_ABOVE_MAX,
		DEFECT_TRUNCATED
	} defect_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	byte_item_t  byte_item;
	logic        empty;
	logic        pop;
	result_t     result;
	int unsigned fail_count;
	int unsigned results_outstanding;

	logic [7:0]  byte_q[$];   // bytes of the buffer being sent
	bit          sender_burst;
	int unsigned cycle_count;

	utf8_stream_decoder_validator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.byte_item (byte_item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	utf8_decode_checker decode_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.byte_item           (byte_item),
		.empty               (empty),
		.pop                 (pop),
		.result              (result),
		.fail_count          (fail_count),
		.results_outstanding (results_outstanding)
	);

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// Append the UTF-8 encoding of cp at the given width. Used for overlong and
	// above-maximum forms as well, so the bits are taken as they come.
	task automatic add_char(logic [20:0] cp, int unsigned width);
		case (width)
			1: byte_q.push_back({1'b0, cp[6:0]});
			2: begin
				byte_q.push_back({3'b110, cp[10:6]});
				byte_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				byte_q.push_back({4'b1110, cp[15:12]});
				byte_q.push_back({2'b10, cp[11:6]});
				byte_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				byte_q.push_back({5'b11110, cp[20:18]});
				byte_q.push_back({2'b10, cp[17:12]});
				byte_q.push_back({2'b10, cp[11:6]});
				byte_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// a scalar value that is well formed at the given width
	function automatic logic [20:0] random_scalar(int unsigned width);
		int unsigned r;
		case (width)
			1: r = $urandom_range(0, 'h7F);
			2: r = $urandom_range('h80, 'h7FF);
			3: begin
				// skip over the surrogate block
				r = $urandom_range('h800, 'hF7FF);
				if (r >= 'hD800) r = r + 'h800;
			end
			default: r = $urandom_range('h10000, 'h10FFFF);
		endcase
		return r[20:0];
	endfunction

	// Mostly well-formed characters; each segment is spoilt by a defect with odds of 28
	// in 100, which ends the buffer; after a defect at most a couple of noise bytes trail
	// (the decoder ignores those but for the end byte, so they count as one item).
	task automatic build_random_buffer(output int unsigned counted);
		int unsigned segs;
		int unsigned w;
		int unsigned k;
		int unsigned r;
		int unsigned trail;
		defect_t     kind;
		bit          broken;
		byte_q.delete();
		segs   = $urandom_range(1, 6);
		broken = 1'b0;
		kind   = DEFECT_NOISE;
		for (int unsigned i = 0; i < segs && !broken; i++) begin
			if ($urandom_range(0, 99) < 72) begin
				w = $urandom_range(1, 4);
				add_char(random_scalar(w), w);
			end else begin
				broken = 1'b1;
				kind   = defect_t'($urandom_range(0, 7));
				case (kind)
					DEFECT_NOISE: byte_q.push_back($urandom_range(0, 255));
					DEFECT_STRAY: byte_q.push_back($urandom_range('h80, 'hBF));
					DEFECT_BAD_LEAD: begin
						if ($urandom_range(0, 1)) byte_q.push_back($urandom_range('hC0, 'hC1));
						else byte_q.push_back($urandom_range('hF5, 'hFF));
					end
					DEFECT_MISSING, DEFECT_TRUNCATED: begin
						// lead plus some but not all continuations
						w = $urandom_range(2, 4);
						k = $urandom_range(0, w - 2);
						add_char(random_scalar(w), w);
						repeat (w - 1 - k) void'(byte_q.pop_back());
						if (kind == DEFECT_MISSING) begin
							// anything but a continuation byte
							r = $urandom_range(0, 191);
							byte_q.push_back(r < 128 ? r : r + 64);
						end
					end
					DEFECT_OVERLONG: begin
						w = $urandom_range(2, 4);
						case (w)
							2: add_char($urandom_range(0, 'h7F), w);
							3: add_char($urandom_range(0, 'h7FF), w);
							default: add_char($urandom_range(0, 'hFFFF), w);
						endcase
					end
					DEFECT_SURROGATE: add_char($urandom_range('hD800, 'hDFFF), 3);
					default: add_char($urandom_range('h110000, 'h1FFFFF), 4);
				endcase
			end
		end
		counted = byte_q.size();
		// a truncated sequence must stay open at the end byte
		if (broken && kind != DEFECT_TRUNCATED) begin
			trail = $urandom_range(0, 2);
			repeat (trail) byte_q.push_back($urandom_range(0, 255));
			if (trail != 0) counted++;
		end
	endtask

	// Offer each byte of byte_q in turn, flagging the last. push stays high
	// across back-to-back items and is only lowered for a gap.
	task automatic send_buffer();
		int unsigned gap;
		sender_burst = ($urandom_range(0, 3) == 0);
		for (int unsigned i = 0; i < byte_q.size(); i++) begin
			gap = sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
			repeat (gap) @(negedge clk) push <= 1'b0;
			@(negedge clk);
			push      <= 1'b1;
			byte_item <= '{data_byte: byte_q[i], end_of_buffer: (i == byte_q.size() - 1)};
			do @(posedge clk); while (full);
		end
	endtask

	// stop offering and wait until every expected result has been taken
	task automatic wait_drained();
		@(negedge clk) push <= 1'b0;
		do @(posedge clk); while (results_outstanding != 0);
	endtask

	// sender: reset, directed buffers, random buffers, verdict
	initial begin : sender
		int unsigned items_sent;
		int unsigned counted;
		bit          paused;
		arst_n     = 1'b0;
		push       = 1'b0;
		byte_item  = '0;
		items_sent = 0;
		paused     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// width extremes in one valid buffer, closed by 0x7F
		byte_q.delete();
		add_char(21'h00080, 2);
		add_char(21'h0FFFF, 3);
		add_char(MAX_SCALAR, 4);
		add_char(21'h0007F, 1);
		send_buffer();
		// stray continuation on the end byte
		byte_q.delete();
		byte_q.push_back(8'h80);
		send_buffer();
		// C0 lead, then a byte that is ignored apart from closing the buffer
		byte_q.delete();
		byte_q.push_back(8'hC0);
		byte_q.push_back(8'h41);
		send_buffer();
		// lead above F4
		byte_q.delete();
		byte_q.push_back(8'hFF);
		send_buffer();
		// missing continuation on the end byte: error and verdict together
		byte_q.delete();
		byte_q.push_back(8'hE0);
		byte_q.push_back(8'h41);
		send_buffer();
		// overlong three-byte form
		byte_q.delete();
		add_char(21'h0, 3);
		send_buffer();
		// surrogate
		byte_q.delete();
		add_char(SURR_LO, 3);
		send_buffer();
		// just above the top scalar
		byte_q.delete();
		add_char(MAX_SCALAR + 21'd1, 4);
		send_buffer();
		// lead alone, cut short by the buffer end
		byte_q.delete();
		byte_q.push_back(8'hC2);
		send_buffer();
		wait_drained();

		while (items_sent < RANDOM_ITEMS) begin
			build_random_buffer(counted);
			send_buffer();
			items_sent += counted;
			// one pause halfway, letting the block run dry
			if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// receiver: after each taken result, idle for a drawn number of cycles,
	// now and then in bursts with no idling, and once for a long hold-off
	initial begin : receiver
		int unsigned wait_left;
		int unsigned taken;
		bit          took;
		bit          burst;
		pop       = 1'b0;
		wait_left = 0;
		taken     = 0;
		burst     = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			took = pop && !empty;
			@(negedge clk);
			if (took) begin
				taken++;
				if (taken % 32 == 0) burst = ($urandom_range(0, 3) == 0);
				wait_left = burst ? 0 : $urandom_range(0, MAX_IDLE);
				if (taken == HOLD_AFTER) wait_left = LONG_HOLD;
			end
			if (wait_left != 0) begin
				pop <= 1'b0;
				wait_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
